>>> rtl/anflt_pkg.sv
package anflt_pkg;

    // Widths of the result fields on the ports.
    localparam int unsigned IDX_W  = 32;
    localparam int unsigned POS_W  = 20;

    // Character codes the lexer reacts to.
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_OPEN   = 8'h28;
    localparam logic [7:0] CH_CLOSE  = 8'h29;
    localparam logic [7:0] CH_SQ_OPEN  = 8'h5B;
    localparam logic [7:0] CH_SQ_CLOSE = 8'h5D;
    localparam logic [7:0] CH_LOW_X  = 8'h78;
    localparam logic [7:0] CH_UP_X   = 8'h58;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef enum logic [3:0] {
        KIND_NUMVAR  = 4'd0,
        KIND_NAMED   = 4'd1,
        KIND_PLUS    = 4'd2,
        KIND_STAR    = 4'd3,
        KIND_COMMA   = 4'd4,
        KIND_CONST0  = 4'd5,
        KIND_CONST1  = 4'd6,
        KIND_LINEEND = 4'd7,
        KIND_ERROR   = 4'd8
    } t_kind;

    typedef enum logic [3:0] {
        ERR_NONE         = 4'd0,
        ERR_NESTED       = 4'd1,
        ERR_STRAY_CLOSE  = 4'd2,
        ERR_PLUS_IN_BR   = 4'd3,
        ERR_BARE_NUMBER  = 4'd4,
        ERR_INDEX_BIG    = 4'd5,
        ERR_BAD_XPAREN   = 4'd6,
        ERR_OPEN_SQUARE  = 4'd7,
        ERR_BARE_X       = 4'd8,
        ERR_BAD_CHAR     = 4'd9,
        ERR_OPEN_BRACKET = 4'd10,
        ERR_LINE_LONG    = 4'd11
    } t_err;

    typedef struct packed {
        t_kind              kind;
        logic [IDX_W-1:0]   index_val;
        logic [POS_W-1:0]   start_pos;
        logic [POS_W-1:0]   name_length;
        t_err               err;
        logic               last;
    } t_result;

    // Results produced by one accepted request: up to two, in order.
    typedef struct packed {
        logic [1:0] cnt;
        t_result    res1;
        t_result    res0;
    } t_lex_out;

    // Occupancy of the result queue.
    typedef struct packed {
        logic [2:0] count;
        logic       full_for_two;
    } t_q_status;

    function automatic t_result mk_res(t_kind k, logic [IDX_W-1:0] idx,
                                       logic [POS_W-1:0] st, logic [POS_W-1:0] ln,
                                       t_err e);
        t_result r;
        r.kind        = k;
        r.index_val   = idx;
        r.start_pos   = st;
        r.name_length = ln;
        r.err         = e;
        r.last        = 1'b0;
        return r;
    endfunction

endpackage

>>> rtl/anflt_lexer.sv
module anflt_lexer
    import anflt_pkg::*;
#(
    parameter int unsigned POS_BITS   = 20,
    parameter int unsigned INDEX_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_ch,
    input  logic       i_end_of_line,
    output t_lex_out   o_lex
);

    localparam int unsigned AW = INDEX_BITS + 4;

    typedef enum logic [4:0] {
        MODE_IDLE   = 5'b00001,
        MODE_NUMBER = 5'b00010,
        MODE_WORD   = 5'b00100,
        MODE_XPAREN = 5'b01000,
        MODE_SQUARE = 5'b10000
    } t_mode;

    t_mode                 r_mode, n_mode;
    logic                  r_inb, n_inb;
    logic [POS_BITS-1:0]   r_pos, n_pos;
    logic [POS_BITS-1:0]   r_begin, n_begin;
    logic [INDEX_BITS-1:0] r_acc, n_acc;
    logic                  r_xd, n_xd;
    logic                  r_digit_seen, n_digit_seen;
    logic                  r_fail, n_fail;

    t_result               res [2];
    logic [1:0]            cnt;
    logic                  do_idle;

    logic                  is_digit, is_alpha, is_word, is_blank, is_x;
    logic [AW-1:0]         acc_ext, prod;
    logic                  acc_ovf;
    logic [31:0]           len32, sq_len32;
    logic                  len_is_one;
    logic [IDX_W-1:0]      acc_out;
    logic [POS_W-1:0]      begin_out;

    assign is_digit = (i_ch >= CH_ZERO) && (i_ch <= CH_NINE);
    assign is_alpha = ((i_ch >= 8'h61) && (i_ch <= 8'h7A)) ||
                      ((i_ch >= 8'h41) && (i_ch <= 8'h5A));
    assign is_word  = is_alpha || is_digit || (i_ch == CH_UNDER);
    assign is_blank = (i_ch == CH_SPACE) || (i_ch == CH_TAB) || (i_ch == CH_CR);
    assign is_x     = (i_ch == CH_LOW_X) || (i_ch == CH_UP_X);

    // Decimal accumulate: acc * 10 + digit, with overflow above the index range.
    assign acc_ext = AW'(r_acc);
    assign prod    = (acc_ext << 3) + (acc_ext << 1) + AW'(i_ch[3:0]);
    assign acc_ovf = |prod[AW-1:INDEX_BITS];

    assign len32      = 32'(r_pos) - 32'(r_begin);
    assign sq_len32   = len32 + 32'd1;
    assign len_is_one = (r_pos == r_begin + POS_BITS'(1));
    assign acc_out    = IDX_W'(r_acc);
    assign begin_out  = POS_W'(32'(r_begin));

    always_comb begin
        n_mode       = r_mode;
        n_inb        = r_inb;
        n_pos        = r_pos;
        n_begin      = r_begin;
        n_acc        = r_acc;
        n_xd         = r_xd;
        n_digit_seen = r_digit_seen;
        n_fail       = r_fail;
        res[0]       = mk_res(KIND_LINEEND, '0, '0, '0, ERR_NONE);
        res[1]       = mk_res(KIND_LINEEND, '0, '0, '0, ERR_NONE);
        cnt          = 2'd0;
        do_idle      = 1'b0;

        if (i_accept) begin
            if (i_end_of_line) begin
                if (r_fail) begin
                    res[0] = mk_res(KIND_LINEEND, '0, '0, '0, ERR_NONE);
                    cnt    = 2'd1;
                end else begin
                    // Flush whatever token is pending.
                    unique case (r_mode)
                        MODE_NUMBER: begin
                            res[0] = mk_res(r_acc[0] ? KIND_CONST1 : KIND_CONST0,
                                            '0, '0, '0, ERR_NONE);
                            cnt    = 2'd1;
                        end
                        MODE_WORD: begin
                            if (r_xd && len_is_one) begin
                                res[0] = mk_res(KIND_ERROR, '0, '0, '0, ERR_BARE_X);
                                n_fail = 1'b1;
                            end else if (r_xd) begin
                                res[0] = mk_res(KIND_NUMVAR, acc_out, '0, '0, ERR_NONE);
                            end else begin
                                res[0] = mk_res(KIND_NAMED, '0, begin_out,
                                                len32[POS_W-1:0], ERR_NONE);
                            end
                            cnt = 2'd1;
                        end
                        MODE_XPAREN: begin
                            res[0] = mk_res(KIND_ERROR, '0, '0, '0, ERR_BAD_XPAREN);
                            n_fail = 1'b1;
                            cnt    = 2'd1;
                        end
                        MODE_SQUARE: begin
                            res[0] = mk_res(KIND_ERROR, '0, '0, '0, ERR_OPEN_SQUARE);
                            n_fail = 1'b1;
                            cnt    = 2'd1;
                        end
                        default: begin
                        end
                    endcase
                    if (!n_fail) begin
                        if (r_inb) begin
                            res[cnt[0]] = mk_res(KIND_ERROR, '0, '0, '0, ERR_OPEN_BRACKET);
                        end else begin
                            res[cnt[0]] = mk_res(KIND_LINEEND, '0, '0, '0, ERR_NONE);
                        end
                        cnt = cnt + 2'd1;
                    end
                end
                // Every end of line returns the lexer to a fresh line.
                n_mode       = MODE_IDLE;
                n_inb        = 1'b0;
                n_pos        = '0;
                n_begin      = '0;
                n_acc        = '0;
                n_xd         = 1'b0;
                n_digit_seen = 1'b0;
                n_fail       = 1'b0;
            end else if (!r_fail) begin
                if (&r_pos) begin
                    res[0] = mk_res(KIND_ERROR, '0, '0, '0, ERR_LINE_LONG);
                    cnt    = 2'd1;
                    n_fail = 1'b1;
                    n_mode = MODE_IDLE;
                end else begin
                    n_pos = r_pos + POS_BITS'(1);
                    unique case (r_mode)
                        MODE_NUMBER: begin
                            if (is_digit) begin
                                res[0] = mk_res(KIND_ERROR, '0, '0, '0, ERR_BARE_NUMBER);
                                n_fail = 1'b1;
                                n_mode = MODE_IDLE;
                            end else begin
                                res[0] = mk_res(r_acc[0] ? KIND_CONST1 : KIND_CONST0,
                                                '0, '0, '0, ERR_NONE);
                                n_mode  = MODE_IDLE;
                                do_idle = 1'b1;
                            end
                            cnt = 2'd1;
                        end
                        MODE_WORD: begin
                            if (is_word) begin
                                if (r_xd) begin
                                    if (is_digit) begin
                                        n_acc = prod[INDEX_BITS-1:0];
                                        if (acc_ovf) begin
                                            res[0] = mk_res(KIND_ERROR, '0, '0, '0,
                                                            ERR_INDEX_BIG);
                                            cnt    = 2'd1;
                                            n_fail = 1'b1;
                                            n_mode = MODE_IDLE;
                                        end
                                    end else begin
                                        n_xd = 1'b0;
                                    end
                                end
                            end else if (r_xd && len_is_one) begin
                                if (i_ch == CH_OPEN) begin
                                    n_mode       = MODE_XPAREN;
                                    n_acc        = '0;
                                    n_digit_seen = 1'b0;
                                end else if (i_ch == CH_SQ_OPEN) begin
                                    n_mode = MODE_SQUARE;
                                end else begin
                                    res[0] = mk_res(KIND_ERROR, '0, '0, '0, ERR_BARE_X);
                                    cnt    = 2'd1;
                                    n_fail = 1'b1;
                                    n_mode = MODE_IDLE;
                                end
                            end else if (i_ch == CH_SQ_OPEN) begin
                                n_mode = MODE_SQUARE;
                            end else begin
                                if (r_xd) begin
                                    res[0] = mk_res(KIND_NUMVAR, acc_out, '0, '0, ERR_NONE);
                                end else begin
                                    res[0] = mk_res(KIND_NAMED, '0, begin_out,
                                                    len32[POS_W-1:0], ERR_NONE);
                                end
                                cnt     = 2'd1;
                                n_mode  = MODE_IDLE;
                                do_idle = 1'b1;
                            end
                        end
                        MODE_XPAREN: begin
                            if (is_digit) begin
                                n_digit_seen = 1'b1;
                                n_acc        = prod[INDEX_BITS-1:0];
                                if (acc_ovf) begin
                                    res[0] = mk_res(KIND_ERROR, '0, '0, '0, ERR_INDEX_BIG);
                                    cnt    = 2'd1;
                                    n_fail = 1'b1;
                                    n_mode = MODE_IDLE;
                                end
                            end else if ((i_ch == CH_CLOSE) && r_digit_seen) begin
                                res[0] = mk_res(KIND_NUMVAR, acc_out, '0, '0, ERR_NONE);
                                cnt    = 2'd1;
                                n_mode = MODE_IDLE;
                            end else begin
                                res[0] = mk_res(KIND_ERROR, '0, '0, '0, ERR_BAD_XPAREN);
                                cnt    = 2'd1;
                                n_fail = 1'b1;
                                n_mode = MODE_IDLE;
                            end
                        end
                        MODE_SQUARE: begin
                            if (i_ch == CH_SQ_CLOSE) begin
                                res[0] = mk_res(KIND_NAMED, '0, begin_out,
                                                sq_len32[POS_W-1:0], ERR_NONE);
                                cnt    = 2'd1;
                                n_mode = MODE_IDLE;
                            end
                        end
                        default: begin
                            do_idle = 1'b1;
                        end
                    endcase

                    // Character seen between tokens.
                    if (do_idle && !is_blank) begin
                        priority if (i_ch == CH_OPEN) begin
                            if (r_inb) begin
                                res[cnt[0]] = mk_res(KIND_ERROR, '0, '0, '0, ERR_NESTED);
                                cnt         = cnt + 2'd1;
                                n_fail      = 1'b1;
                            end else begin
                                n_inb = 1'b1;
                            end
                        end else if (i_ch == CH_CLOSE) begin
                            if (!r_inb) begin
                                res[cnt[0]] = mk_res(KIND_ERROR, '0, '0, '0,
                                                     ERR_STRAY_CLOSE);
                                cnt         = cnt + 2'd1;
                                n_fail      = 1'b1;
                            end else begin
                                n_inb = 1'b0;
                            end
                        end else if (i_ch == CH_PLUS) begin
                            if (r_inb) begin
                                res[cnt[0]] = mk_res(KIND_ERROR, '0, '0, '0, ERR_PLUS_IN_BR);
                                n_fail      = 1'b1;
                            end else begin
                                res[cnt[0]] = mk_res(KIND_PLUS, '0, '0, '0, ERR_NONE);
                            end
                            cnt = cnt + 2'd1;
                        end else if (i_ch == CH_STAR) begin
                            res[cnt[0]] = mk_res(KIND_STAR, '0, '0, '0, ERR_NONE);
                            cnt         = cnt + 2'd1;
                        end else if (i_ch == CH_COMMA) begin
                            res[cnt[0]] = mk_res(KIND_COMMA, '0, '0, '0, ERR_NONE);
                            cnt         = cnt + 2'd1;
                        end else if (is_digit) begin
                            if ((i_ch == CH_ZERO) || (i_ch == CH_ONE)) begin
                                n_mode       = MODE_NUMBER;
                                n_acc        = INDEX_BITS'(i_ch[0]);
                                n_digit_seen = 1'b1;
                            end else begin
                                res[cnt[0]] = mk_res(KIND_ERROR, '0, '0, '0,
                                                     ERR_BARE_NUMBER);
                                cnt         = cnt + 2'd1;
                                n_fail      = 1'b1;
                            end
                        end else if (is_alpha || (i_ch == CH_UNDER)) begin
                            n_mode  = MODE_WORD;
                            n_begin = r_pos;
                            n_acc   = '0;
                            n_xd    = is_x;
                        end else begin
                            res[cnt[0]] = mk_res(KIND_ERROR, '0, '0, '0, ERR_BAD_CHAR);
                            cnt         = cnt + 2'd1;
                            n_fail      = 1'b1;
                        end
                    end
                end
            end
        end

        if (cnt == 2'd1) begin
            res[0].last = 1'b1;
        end else if (cnt == 2'd2) begin
            res[1].last = 1'b1;
        end
    end

    assign o_lex.cnt  = cnt;
    assign o_lex.res0 = res[0];
    assign o_lex.res1 = res[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_IDLE;
            r_inb        <= 1'b0;
            r_pos        <= '0;
            r_begin      <= '0;
            r_acc        <= '0;
            r_xd         <= 1'b0;
            r_digit_seen <= 1'b0;
            r_fail       <= 1'b0;
        end else begin
            r_mode       <= n_mode;
            r_inb        <= n_inb;
            r_pos        <= n_pos;
            r_begin      <= n_begin;
            r_acc        <= n_acc;
            r_xd         <= n_xd;
            r_digit_seen <= n_digit_seen;
            r_fail       <= n_fail;
        end
    end

endmodule

>>> rtl/anflt_outq.sv
module anflt_outq
    import anflt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_lex_out  i_lex,
    input  logic      i_pop,
    output t_result   o_head,
    output logic      o_valid,
    output t_q_status o_status
);

    localparam int unsigned DEPTH = 4;

    t_result    r_mem [DEPTH];
    logic [1:0] r_wp, n_wp;
    logic [1:0] r_rp, n_rp;
    logic [2:0] r_count, n_count;
    logic       pop;

    assign o_valid = (r_count != 3'd0);
    assign pop     = i_pop && o_valid;
    assign o_head  = r_mem[r_rp];

    // Room for two results is kept so that any request can be taken.
    assign o_status.count        = r_count;
    assign o_status.full_for_two = (r_count > 3'd2);

    always_comb begin
        n_wp    = r_wp + i_lex.cnt;
        n_rp    = r_rp + {1'b0, pop};
        n_count = r_count + {1'b0, i_lex.cnt} - {2'b00, pop};
    end

    always_ff @(posedge i_clk) begin
        if (i_lex.cnt != 2'd0) begin
            r_mem[r_wp] <= i_lex.res0;
        end
        if (i_lex.cnt == 2'd2) begin
            r_mem[r_wp + 2'd1] <= i_lex.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

endmodule

>>> rtl/anf_line_tokenizer.sv
// A request's results are written into the result queue when it is accepted
// and offered from its head. Throughput: one character per cycle unless input
// is stalled; a request may yield two results (a flushed token and the next one).
// The four-entry result queue stalls input when fewer than two places are free.
// Reset: synchronous, active low; lexer state and the result queue are cleared.
module anf_line_tokenizer
    import anflt_pkg::*;
#(
    parameter int unsigned POS_BITS   = 20,
    parameter int unsigned INDEX_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_ch,
    input  logic        i_end_of_line,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_token_kind,
    output logic [31:0] o_var_index,
    output logic [19:0] o_name_start,
    output logic [19:0] o_name_length,
    output logic [3:0]  o_error_code,
    output logic        o_last
);

    t_lex_out  lex;
    t_result   head;
    t_q_status qstat;
    logic      accept;

    // A request is taken whenever the queue can absorb the worst case of two
    // results, independent of what the downstream side does this cycle.
    assign o_in_stall = qstat.full_for_two;
    assign accept     = i_in_valid && !o_in_stall;

    // The lexer state registers are updated in the same cycle a character is
    // accepted; the results it produces land directly in the queue.
    anflt_lexer #(
        .POS_BITS   (POS_BITS),
        .INDEX_BITS (INDEX_BITS)
    ) u_lexer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_ch          (i_ch),
        .i_end_of_line (i_end_of_line),
        .o_lex         (lex)
    );

    // The queue head is the output register that decouples the two sides.
    anflt_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_lex    (lex),
        .i_pop    (!i_out_stall),
        .o_head   (head),
        .o_valid  (o_out_valid),
        .o_status (qstat)
    );

    assign o_token_kind  = head.kind;
    assign o_var_index   = head.index_val;
    assign o_name_start  = head.start_pos;
    assign o_name_length = head.name_length;
    assign o_error_code  = head.err;
    assign o_last        = head.last;

`ifndef SYNTHESIS
    a_queue_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        qstat.count <= 3'd4)
        else $error("result queue overflow");

    a_eol_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_end_of_line) |-> (lex.cnt != 2'd0))
        else $error("end of line produced no result");

    a_no_result_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |-> (lex.cnt == 2'd0))
        else $error("result produced without an accepted request");

    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("results visible after reset");
`endif

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

// Testbench for the polynomial line lexer. Lines are fed one character per
// request, and every request is run through a lexer model kept in this file.
// The model queues the tokens that each request must produce, and a checker
// compares each token the block hands out against the oldest queued one.
// Both sides of the block idle at random, and one phase holds the token side
// off long enough that the block must stall its character input.
module testbench;
    import anflt_pkg::*;

    // Longest stretch without any handshake before the run is declared hung.
    // The long hold-off phase is far shorter, so this leaves a wide margin.
    localparam int QUIET_LIMIT = 3000;
    localparam logic [POS_W-1:0] POS_LIMIT = '1;
    localparam logic [63:0] INDEX_LIMIT = 64'hFFFF_FFFF;

    // Modes of the lexer model, the same walk the block makes.
    typedef enum logic [2:0] {
        LEX_IDLE,
        LEX_NUMBER,
        LEX_WORD,
        LEX_XPAREN,
        LEX_SQUARE
    } t_lex_mode;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  ch;
    logic        eol;
    logic        out_valid;
    logic        out_stall;
    logic [3:0]  tok_kind;
    logic [31:0] tok_index;
    logic [19:0] tok_start;
    logic [19:0] tok_length;
    logic [3:0]  tok_err;
    logic        tok_last;

    anf_line_tokenizer dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_ch          (ch),
        .i_end_of_line (eol),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_token_kind  (tok_kind),
        .o_var_index   (tok_index),
        .o_name_start  (tok_start),
        .o_name_length (tok_length),
        .o_error_code  (tok_err),
        .o_last        (tok_last)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Tokens still owed by the block, oldest first.
    t_result tokens_due[$];
    t_result want;
    int      mismatches = 0;
    int      requests_sent = 0;
    int      quiet_cycles = 0;

    // Idling limits for both sides, changed from phase to phase. A limit of
    // zero gives a stretch where that side never idles.
    int send_max = 0;
    int recv_max = 0;
    int hold_cycles = 0;

    // Characters of the line being built, sent by send_line.
    logic [7:0] line_q[$];

    // ------------------------------------------------------------------
    // Lexer model state.
    // ------------------------------------------------------------------
    t_lex_mode        lx_mode;
    logic             lx_in_br;
    logic [POS_W-1:0] lx_pos;
    logic [POS_W-1:0] lx_begin;
    logic [63:0]      lx_acc;
    logic             lx_xdig;
    logic [1:0]       lx_runs;
    logic             lx_failed;
    t_result          step_tok[2];
    int               step_cnt;

    function automatic bit is_dig(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_word(logic [7:0] c);
        return is_alpha(c) || is_dig(c) || c == CH_UNDER;
    endfunction

    // At most two tokens come out of one request; any further one is lost,
    // exactly as the block drops it.
    function automatic void add_token(t_kind k, logic [31:0] idx, logic [POS_W-1:0] st,
                                      logic [POS_W-1:0] ln, t_err e);
        t_result r;
        if (step_cnt >= 2) return;
        r.kind        = k;
        r.index_val   = idx;
        r.start_pos   = st;
        r.name_length = ln;
        r.err         = e;
        r.last        = 1'b0;
        step_tok[step_cnt] = r;
        step_cnt++;
    endfunction

    // The first error of a line is reported and the rest of it is skipped.
    function automatic void lex_fail(t_err e);
        add_token(KIND_ERROR, '0, '0, '0, e);
        lx_failed = 1'b1;
        lx_mode   = LEX_IDLE;
    endfunction

    function automatic void lex_clear();
        lx_mode   = LEX_IDLE;
        lx_in_br  = 1'b0;
        lx_pos    = '0;
        lx_begin  = '0;
        lx_acc    = '0;
        lx_xdig   = 1'b0;
        lx_runs   = '0;
        lx_failed = 1'b0;
    endfunction

    function automatic void lex_digit(logic [7:0] c);
        lx_acc = lx_acc * 64'd10 + 64'(c - CH_ZERO);
        if (lx_acc > INDEX_LIMIT) lex_fail(ERR_INDEX_BIG);
    endfunction

    function automatic void lex_flush_const();
        add_token(lx_acc[0] ? KIND_CONST1 : KIND_CONST0, '0, '0, '0, ERR_NONE);
    endfunction

    // A character seen between tokens.
    function automatic void lex_between(logic [7:0] c, logic [POS_W-1:0] pos);
        if (c == CH_SPACE || c == CH_TAB || c == CH_CR) return;
        if (c == CH_OPEN) begin
            if (lx_in_br) lex_fail(ERR_NESTED);
            else lx_in_br = 1'b1;
        end else if (c == CH_CLOSE) begin
            if (!lx_in_br) lex_fail(ERR_STRAY_CLOSE);
            else lx_in_br = 1'b0;
        end else if (c == CH_PLUS) begin
            if (lx_in_br) lex_fail(ERR_PLUS_IN_BR);
            else add_token(KIND_PLUS, '0, '0, '0, ERR_NONE);
        end else if (c == CH_STAR) begin
            add_token(KIND_STAR, '0, '0, '0, ERR_NONE);
        end else if (c == CH_COMMA) begin
            add_token(KIND_COMMA, '0, '0, '0, ERR_NONE);
        end else if (is_dig(c)) begin
            if (c == CH_ZERO || c == CH_ONE) begin
                lx_mode = LEX_NUMBER;
                lx_acc  = (c == CH_ONE) ? 64'd1 : 64'd0;
                lx_runs = 2'd1;
            end else begin
                lex_fail(ERR_BARE_NUMBER);
            end
        end else if (is_alpha(c) || c == CH_UNDER) begin
            lx_mode  = LEX_WORD;
            lx_begin = pos;
            lx_acc   = '0;
            lx_xdig  = (c == CH_LOW_X || c == CH_UP_X);
        end else begin
            lex_fail(ERR_BAD_CHAR);
        end
    endfunction

    function automatic void lex_char(logic [7:0] c);
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] len;
        if (lx_failed) return;
        pos = lx_pos;
        if (pos == POS_LIMIT) begin
            lex_fail(ERR_LINE_LONG);
            return;
        end
        lx_pos = pos + 1'b1;
        case (lx_mode)
            LEX_NUMBER: begin
                // Only a lone 0 or 1 is a constant.
                if (is_dig(c)) begin
                    lex_fail(ERR_BARE_NUMBER);
                    return;
                end
                lex_flush_const();
                lx_mode = LEX_IDLE;
                lex_between(c, pos);
            end
            LEX_WORD: begin
                if (is_word(c)) begin
                    if (lx_xdig) begin
                        if (is_dig(c)) lex_digit(c);
                        else lx_xdig = 1'b0;
                    end
                    return;
                end
                len = pos - lx_begin;
                // A lone x may only open x(N) or a square suffix.
                if (lx_xdig && len == 1) begin
                    if (c == CH_OPEN) begin
                        lx_mode = LEX_XPAREN;
                        lx_acc  = '0;
                        lx_runs = '0;
                    end else if (c == CH_SQ_OPEN) begin
                        lx_mode = LEX_SQUARE;
                    end else begin
                        lex_fail(ERR_BARE_X);
                    end
                    return;
                end
                // Any word, x<N> too, turns into a name when a suffix follows.
                if (c == CH_SQ_OPEN) begin
                    lx_mode = LEX_SQUARE;
                    return;
                end
                if (lx_xdig) add_token(KIND_NUMVAR, lx_acc[31:0], '0, '0, ERR_NONE);
                else add_token(KIND_NAMED, '0, lx_begin, len, ERR_NONE);
                lx_mode = LEX_IDLE;
                lex_between(c, pos);
            end
            LEX_XPAREN: begin
                if (is_dig(c)) begin
                    lx_runs = 2'd1;
                    lex_digit(c);
                end else if (c == CH_CLOSE && lx_runs != 0) begin
                    add_token(KIND_NUMVAR, lx_acc[31:0], '0, '0, ERR_NONE);
                    lx_mode = LEX_IDLE;
                end else begin
                    lex_fail(ERR_BAD_XPAREN);
                end
            end
            LEX_SQUARE: begin
                if (c == CH_SQ_CLOSE) begin
                    add_token(KIND_NAMED, '0, lx_begin, pos - lx_begin + 1'b1, ERR_NONE);
                    lx_mode = LEX_IDLE;
                end
            end
            default: begin
                lx_mode = LEX_IDLE;
                lex_between(c, pos);
            end
        endcase
    endfunction

    // End of line: flush what is pending, then check the brackets.
    function automatic void lex_eol();
        logic [POS_W-1:0] len;
        if (lx_failed) begin
            add_token(KIND_LINEEND, '0, '0, '0, ERR_NONE);
            lex_clear();
            return;
        end
        case (lx_mode)
            LEX_NUMBER: lex_flush_const();
            LEX_WORD: begin
                len = lx_pos - lx_begin;
                if (lx_xdig && len == 1) lex_fail(ERR_BARE_X);
                else if (lx_xdig) add_token(KIND_NUMVAR, lx_acc[31:0], '0, '0, ERR_NONE);
                else add_token(KIND_NAMED, '0, lx_begin, len, ERR_NONE);
            end
            LEX_XPAREN: lex_fail(ERR_BAD_XPAREN);
            LEX_SQUARE: lex_fail(ERR_OPEN_SQUARE);
            default: ;
        endcase
        if (!lx_failed) begin
            if (lx_in_br) lex_fail(ERR_OPEN_BRACKET);
            else add_token(KIND_LINEEND, '0, '0, '0, ERR_NONE);
        end
        lex_clear();
    endfunction

    // Runs one accepted request through the model and queues its tokens,
    // with last set on the final one.
    function automatic void lex_request(logic [7:0] c, logic end_line);
        t_result r;
        step_cnt = 0;
        if (end_line) lex_eol();
        else lex_char(c);
        for (int i = 0; i < step_cnt; i++) begin
            r = step_tok[i];
            r.last = (i == step_cnt - 1);
            tokens_due.insert(tokens_due.size(), r);
        end
    endfunction

    // ------------------------------------------------------------------
    // Request side.
    // ------------------------------------------------------------------

    // Sends one request after a random idle gap. While idle, the character
    // lines carry noise. The payload is held until the block accepts it.
    task automatic send_req(input logic [7:0] c, input logic end_line);
        int gap;
        gap = (send_max > 0) ? $urandom_range(0, send_max) : 0;
        repeat (gap) begin
            @(negedge clk);
            in_valid <= 1'b0;
            ch       <= 8'($urandom);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        ch       <= c;
        eol      <= end_line;
        do @(posedge clk); while (in_stall);
        lex_request(c, end_line);
        requests_sent++;
    endtask

    // Sends the built line, then the end of line with a random character.
    task automatic send_line();
        foreach (line_q[i]) send_req(line_q[i], 1'b0);
        send_req(8'($urandom), 1'b1);
        line_q.delete();
    endtask

    // Takes the last request off the input before waiting, so that it is
    // not accepted a second time.
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (tokens_due.size() != 0) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Line builders.
    // ------------------------------------------------------------------
    function automatic void put_ch(logic [7:0] c);
        line_q.insert(line_q.size(), c);
    endfunction

    function automatic void put_str(string s);
        foreach (s[i]) put_ch(s[i]);
    endfunction

    function automatic logic [7:0] pick_from(string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    function automatic logic [7:0] word_char();
        return pick_from("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_");
    endfunction

    // Blanks are dropped by the block, so they are sprinkled freely.
    function automatic void put_blanks();
        repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0)
            put_ch(pick_from(" \t\r"));
    endfunction

    function automatic void put_op(logic [7:0] c);
        put_blanks();
        put_ch(c);
        put_blanks();
    endfunction

    function automatic string index_text();
        logic [31:0] v;
        case ($urandom_range(0, 3))
            0: v = $urandom_range(0, 20);
            1: v = $urandom;
            2: v = 32'hFFFF_FFFF;
            default: v = $urandom_range(0, 999);
        endcase
        return ($urandom_range(0, 4) == 0) ? $sformatf("0%0d", v) : $sformatf("%0d", v);
    endfunction

    function automatic void put_name();
        put_ch(pick_from("abcxyzXQ_"));
        repeat ($urandom_range(0, 6)) put_ch(word_char());
    endfunction

    // A square suffix may hold any character but the closing one.
    function automatic void put_square();
        logic [7:0] b;
        put_ch(CH_SQ_OPEN);
        repeat ($urandom_range(0, 4)) begin
            b = 8'($urandom_range(0, 255));
            if (b == CH_SQ_CLOSE) b = CH_SPACE;
            put_ch(b);
        end
    endfunction

    function automatic void put_factor();
        case ($urandom_range(0, 7))
            0: put_ch(pick_from("01"));
            1, 2: begin
                put_ch(pick_from("xX"));
                put_str(index_text());
            end
            3: begin
                put_ch(pick_from("xX"));
                put_str({"(", index_text(), ")"});
            end
            4, 5: put_name();
            6: begin
                // A numbered variable or a bare x with a suffix is a name.
                put_ch(pick_from("xX"));
                if ($urandom_range(0, 1)) put_str(index_text());
                put_square();
                put_ch(CH_SQ_CLOSE);
            end
            default: begin
                put_name();
                put_square();
                put_ch(CH_SQ_CLOSE);
            end
        endcase
    endfunction

    // Terms joined by plus, factors by star or comma, and at most one
    // term wrapped in round brackets.
    function automatic void put_wellformed();
        int terms;
        int br_term;
        terms   = $urandom_range(1, 5);
        br_term = $urandom_range(0, 2) == 0 ? $urandom_range(0, terms - 1) : -1;
        for (int t = 0; t < terms; t++) begin
            if (t > 0) put_op(CH_PLUS);
            if (t == br_term) put_op(CH_OPEN);
            for (int f = $urandom_range(1, 3); f > 0; f--) begin
                put_factor();
                if (f > 1) put_op(pick_from("*,"));
            end
            if (t == br_term) put_op(CH_CLOSE);
        end
    endfunction

    // Builds a line that runs into the given error after a clean prefix.
    // Returns 1 when the error only shows at the end of the line, so
    // nothing may follow the pattern.
    function automatic bit put_error(t_err code);
        logic [7:0] b;
        if ($urandom_range(0, 1)) begin
            put_factor();
            put_op(pick_from("*,+"));
        end
        case (code)
            ERR_NESTED: begin
                if ($urandom_range(0, 1)) put_str("((");
                else put_str("(a*(");
            end
            ERR_STRAY_CLOSE: put_ch(CH_CLOSE);
            ERR_PLUS_IN_BR: begin
                put_ch(CH_OPEN);
                put_factor();
                put_op(CH_PLUS);
            end
            ERR_BARE_NUMBER: begin
                if ($urandom_range(0, 1)) begin
                    put_ch(pick_from("23456789"));
                end else begin
                    put_ch(pick_from("01"));
                    put_ch(pick_from("0123456789"));
                end
            end
            ERR_INDEX_BIG: begin
                put_ch(pick_from("xX"));
                b = pick_from("(9");
                if (b == CH_OPEN) put_ch(b);
                put_str($sformatf("%0d", 64'd4294967296 + $urandom_range(0, 99999)));
            end
            ERR_BAD_XPAREN: begin
                put_str("x(");
                case ($urandom_range(0, 3))
                    0: put_ch(CH_CLOSE);
                    1: put_str(" 3)");
                    2: begin
                        put_ch("7");
                        put_ch(pick_from("a[ +"));
                    end
                    default: begin
                        if ($urandom_range(0, 1)) put_str("42");
                        return 1'b1;
                    end
                endcase
            end
            ERR_OPEN_SQUARE: begin
                put_name();
                put_square();
                return 1'b1;
            end
            ERR_BARE_X: begin
                put_ch(pick_from("xX"));
                if ($urandom_range(0, 2) == 0) return 1'b1;
                put_ch(pick_from(" +*,)]"));
            end
            ERR_BAD_CHAR: begin
                do b = 8'($urandom_range(0, 255));
                while (is_word(b) || b == CH_SPACE || b == CH_TAB || b == CH_CR ||
                       b == CH_OPEN || b == CH_CLOSE || b == CH_PLUS ||
                       b == CH_STAR || b == CH_COMMA);
                put_ch(b);
            end
            default: begin
                put_ch(CH_OPEN);
                put_factor();
                return 1'b1;
            end
        endcase
        return 1'b0;
    endfunction

    // Anything at all, biased toward the characters the lexer cares about.
    function automatic void put_noise();
        repeat ($urandom_range(0, 16)) begin
            if ($urandom_range(0, 1)) put_ch(8'($urandom_range(0, 255)));
            else put_ch(pick_from(" x(1)[]+*,0_aX9"));
        end
    endfunction

    function automatic int pick_idle();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 3;
            default: return 12;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Token side: random stall before each token, and a long hold-off
    // when a test asks for one.
    // ------------------------------------------------------------------
    initial begin
        int n;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            if (hold_cycles != 0) begin
                n = hold_cycles;
                hold_cycles = 0;
                repeat (n) begin
                    @(negedge clk);
                    out_stall <= 1'b1;
                end
            end
            n = (recv_max > 0) ? $urandom_range(0, recv_max) : 0;
            repeat (n) begin
                @(negedge clk);
                out_stall <= 1'b1;
            end
            @(negedge clk);
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] exp_val);
        mismatches++;
        if (mismatches <= 100)
            $display("%0t: %s: got %0h, expected %0h", $realtime, what, got, exp_val);
    endtask

    // Each accepted token is checked against the oldest one owed.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (tokens_due.size() == 0) begin
                report_mismatch("token with none owed, kind", tok_kind, '0);
            end else begin
                want = tokens_due.pop_front();
                if (tok_kind !== want.kind)
                    report_mismatch("token_kind", tok_kind, want.kind);
                if (tok_index !== want.index_val)
                    report_mismatch("variable index", tok_index, want.index_val);
                if (tok_start !== want.start_pos)
                    report_mismatch("name begin", tok_start, want.start_pos);
                if (tok_length !== want.name_length)
                    report_mismatch("name_length", tok_length, want.name_length);
                if (tok_err !== want.err)
                    report_mismatch("error_code", tok_err, want.err);
                if (tok_last !== want.last)
                    report_mismatch("last", tok_last, want.last);
            end
        end
    end

    // Ends the run when no handshake has happened for too long.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Every token kind but the error kind, the largest index, a bracket group, a
    // square suffix, and two tokens from one request both in mid line and at end of line.
    task automatic test_token_kinds();
        send_max = 0;
        recv_max = 0;
        put_str("x0*X4294967295+(_a1[q]),1 0");
        send_line();
        wait_drained();
    endtask

    // Each error code but the line-too-long one a few times, with junk after it that must be skipped.
    task automatic test_error_lines();
        bit ends_line;
        for (int rep = 0; rep < 4; rep++) begin
            for (int k = ERR_NESTED; k <= ERR_OPEN_BRACKET; k++) begin
                send_max = pick_idle();
                recv_max = pick_idle();
                ends_line = put_error(t_err'(k));
                if (!ends_line) put_noise();
                send_line();
            end
        end
        wait_drained();
    endtask

    // The token side holds off for a long stretch while requests keep
    // coming at full rate, so the block's queue fills and it stalls input.
    task automatic test_backpressure();
        send_max = 0;
        recv_max = 0;
        hold_cycles = 300;
        repeat (30) begin
            put_factor();
            put_op(pick_from("*,+"));
        end
        put_factor();
        send_line();
        wait_drained();
    endtask

    // Mostly well-formed lines with random content, the rest lines with an
    // error and plain noise, under changing idle patterns.
    task automatic test_random_lines();
        int start;
        int pick;
        bit ends_line;
        start = requests_sent;
        while (requests_sent - start < 1000) begin
            send_max = pick_idle();
            recv_max = pick_idle();
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                put_wellformed();
            end else if (pick < 85) begin
                ends_line = put_error(t_err'($urandom_range(ERR_NESTED, ERR_OPEN_BRACKET)));
                if (!ends_line) put_noise();
            end else begin
                put_noise();
            end
            send_line();
        end
        wait_drained();
    endtask

    initial begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        ch       = '0;
        eol      = 1'b0;
        lex_clear();
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        test_token_kinds();
        test_error_lines();
        test_backpressure();
        test_random_lines();

        @(negedge clk);
        in_valid <= 1'b0;
        wait_drained();
        // Let a few more cycles pass so that a stray extra token is caught.
        repeat (10) @(posedge clk);
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/anflt_pkg.sv
rtl/anflt_lexer.sv
rtl/anflt_outq.sv
rtl/anf_line_tokenizer.sv
tb/testbench.sv
